/* rtl/mase_pkg.sv */
package mase_pkg;

  localparam int MAX_DIM    = 8;
  localparam int ELEM_WIDTH = 32;

  // Field widths fixed by the interface.
  localparam int REQ_W   = 3;
  localparam int IDX_W   = 3;
  localparam int SIZE_W  = 4;
  localparam int VALUE_W = 32;
  localparam int CFG_IDX_W = 2;
  localparam int ADDR_W  = (MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;

  localparam logic [REQ_W-1:0] REQ_LOAD_A = 3'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_B = 3'd1;
  localparam logic [REQ_W-1:0] REQ_ADD    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_SUB    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_MUL    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_B = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B = 2'd3;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL
  } mac_op_t;

  typedef struct packed {
    logic              valid;
    logic              first;
    logic              last;
    mac_op_t           op;
  } mac_ctl_t;

  typedef struct packed {
    logic [REQ_W-1:0]          req_type;
    logic [IDX_W-1:0]          elem_row;
    logic [IDX_W-1:0]          elem_col;
    logic signed [VALUE_W-1:0] elem_value;
  } in_item_t;

  typedef struct packed {
    logic                      status;
    logic [IDX_W-1:0]          out_row;
    logic [IDX_W-1:0]          out_col;
    logic signed [VALUE_W-1:0] out_value;
    logic                      last;
  } out_item_t;

  // Sizes of 0 act as 1 and sizes above MAX_DIM act as MAX_DIM.
  function automatic logic [SIZE_W-1:0] clamp_dim(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > SIZE_W'(MAX_DIM)) begin
      r = SIZE_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
    logic [2*IDX_W+1:0] a;
    a = (2*IDX_W+2)'(row) * (2*IDX_W+2)'(MAX_DIM) + (2*IDX_W+2)'(col);
    return a[ADDR_W-1:0];
  endfunction

endpackage

/* rtl/mase_mac.sv */
module mase_mac (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mase_pkg::mac_ctl_t                 ctl,
  input  logic [mase_pkg::ELEM_WIDTH-1:0]    a_data,
  input  logic [mase_pkg::ELEM_WIDTH-1:0]    b_data,
  output logic                               done,
  output logic [mase_pkg::ELEM_WIDTH-1:0]    acc
);

  mase_pkg::mac_ctl_t                  p_ctl_r;
  logic [mase_pkg::ELEM_WIDTH-1:0]     p_r;
  logic [mase_pkg::ELEM_WIDTH-1:0]     acc_r;
  logic                                done_r;
  logic [mase_pkg::ELEM_WIDTH-1:0]     term;

  always_comb begin
    case (ctl.op)
      mase_pkg::OP_ADD: term = a_data + b_data;
      mase_pkg::OP_SUB: term = a_data - b_data;
      mase_pkg::OP_MUL: term = mase_pkg::ELEM_WIDTH'(a_data * b_data);
      default:          term = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_ctl_r <= '0;
      done_r  <= 1'b0;
    end else begin
      p_ctl_r <= ctl;
      done_r  <= p_ctl_r.valid && p_ctl_r.last;
    end
    p_r <= term;
    if (p_ctl_r.valid) begin
      acc_r <= (p_ctl_r.first ? '0 : acc_r) + p_r;
    end
  end

  assign done = done_r;
  assign acc  = acc_r;

endmodule

/* rtl/matrix_add_sub_mul_engine.sv */
// Channel  Direction  Handshake             Beat
// in_      input      in_valid / in_stall   in_item_t: request, row, column, value
// out_     output     out_valid / out_stall out_item_t: status, row, column, value, last
// cfg_     input      cfg_valid / cfg_ready register index and 4-bit size
//
// A load is written to its element memory and leaves the block idle; a refused run goes straight
// to the output state and presents its mismatch beat from there. For each result element of a
// run, K being A's column count for a multiply and 1 for add or subtract, the K operand pairs are
// read one per cycle from the two element memories and summed through one multiply-accumulate unit.
// A new item is taken only once the previous run has handed its last beat to the output
// register; out_stall holds that register and halts the run. rst_n is synchronous.
// The element memories are not cleared by reset.
module matrix_add_sub_mul_engine (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  mase_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output mase_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mase_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mase_pkg::SIZE_W-1:0]         cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_OUT
  } state_t;

  state_t                              state_r;
  mase_pkg::mac_op_t                   op_r;
  logic                                err_r;
  logic [mase_pkg::SIZE_W-1:0]         nr_r, nc_r, kn_r;
  logic [mase_pkg::IDX_W-1:0]          i_r, j_r, k_r;
  logic [mase_pkg::SIZE_W-1:0]         rows_a_r, cols_a_r, rows_b_r, cols_b_r;
  mase_pkg::mac_ctl_t                  rd_ctl_r;
  logic                                out_valid_r;
  mase_pkg::out_item_t                 out_data_r;

  logic [mase_pkg::ELEM_WIDTH-1:0]     mem_a [mase_pkg::DEPTH];
  logic [mase_pkg::ELEM_WIDTH-1:0]     mem_b [mase_pkg::DEPTH];
  logic [mase_pkg::ELEM_WIDTH-1:0]     rdata_a_r, rdata_b_r;

  logic                                in_acc, out_free, out_load, last_k, last_elem;
  logic [mase_pkg::SIZE_W-1:0]         ra, ca, rb, cb;
  logic [mase_pkg::ADDR_W-1:0]         wr_addr, rd_addr_a, rd_addr_b;
  logic                                wr_a, wr_b;
  logic                                mac_done;
  logic [mase_pkg::ELEM_WIDTH-1:0]     mac_acc;
  logic signed [mase_pkg::ELEM_WIDTH-1:0] mac_acc_s;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = (state_r == S_OUT) && out_free;

  assign ra = mase_pkg::clamp_dim(rows_a_r);
  assign ca = mase_pkg::clamp_dim(cols_a_r);
  assign rb = mase_pkg::clamp_dim(rows_b_r);
  assign cb = mase_pkg::clamp_dim(cols_b_r);

  assign last_k    = (mase_pkg::SIZE_W'(k_r) + mase_pkg::SIZE_W'(1)) == kn_r;
  assign last_elem = ((mase_pkg::SIZE_W'(i_r) + mase_pkg::SIZE_W'(1)) == nr_r) &&
                     ((mase_pkg::SIZE_W'(j_r) + mase_pkg::SIZE_W'(1)) == nc_r);

  assign wr_addr = mase_pkg::elem_addr(in_data.elem_row, in_data.elem_col);
  assign wr_a    = in_acc && (in_data.req_type == mase_pkg::REQ_LOAD_A);
  assign wr_b    = in_acc && (in_data.req_type == mase_pkg::REQ_LOAD_B);

  // A multiply walks row i of A against column j of B; add and subtract read the same entry.
  assign rd_addr_a = (op_r == mase_pkg::OP_MUL) ? mase_pkg::elem_addr(i_r, k_r)
                                                : mase_pkg::elem_addr(i_r, j_r);
  assign rd_addr_b = (op_r == mase_pkg::OP_MUL) ? mase_pkg::elem_addr(k_r, j_r)
                                                : mase_pkg::elem_addr(i_r, j_r);

  // Loads only arrive while no run is active, so no read during a run meets a write to its entry.
  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[wr_addr] <= in_data.elem_value[mase_pkg::ELEM_WIDTH-1:0];
    end
    if (wr_b) begin
      mem_b[wr_addr] <= in_data.elem_value[mase_pkg::ELEM_WIDTH-1:0];
    end
    rdata_a_r <= mem_a[rd_addr_a];
    rdata_b_r <= mem_b[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r <= mase_pkg::SIZE_W'(1);
      cols_a_r <= mase_pkg::SIZE_W'(1);
      rows_b_r <= mase_pkg::SIZE_W'(1);
      cols_b_r <= mase_pkg::SIZE_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mase_pkg::CFG_ROWS_A: rows_a_r <= cfg_data;
        mase_pkg::CFG_COLS_A: cols_a_r <= cfg_data;
        mase_pkg::CFG_ROWS_B: rows_b_r <= cfg_data;
        mase_pkg::CFG_COLS_B: cols_b_r <= cfg_data;
        default: ;
      endcase
    end
  end

  mase_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (rd_ctl_r),
    .a_data (rdata_a_r),
    .b_data (rdata_b_r),
    .done   (mac_done),
    .acc    (mac_acc)
  );

  assign mac_acc_s = mac_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rd_ctl_r    <= '0;
      err_r       <= 1'b0;
      op_r        <= mase_pkg::OP_ADD;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      nr_r        <= mase_pkg::SIZE_W'(1);
      nc_r        <= mase_pkg::SIZE_W'(1);
      kn_r        <= mase_pkg::SIZE_W'(1);
    end else begin
      out_valid_r    <= out_load || (out_valid_r && out_stall);
      rd_ctl_r.valid <= (state_r == S_RUN);
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            i_r <= '0;
            j_r <= '0;
            k_r <= '0;
            nr_r <= ra;
            case (in_data.req_type)
              mase_pkg::REQ_ADD, mase_pkg::REQ_SUB: begin
                op_r  <= (in_data.req_type == mase_pkg::REQ_ADD) ? mase_pkg::OP_ADD
                                                                 : mase_pkg::OP_SUB;
                nc_r  <= ca;
                kn_r  <= mase_pkg::SIZE_W'(1);
                err_r <= (ra != rb) || (ca != cb);
                state_r <= ((ra != rb) || (ca != cb)) ? S_OUT : S_RUN;
              end
              mase_pkg::REQ_MUL: begin
                op_r  <= mase_pkg::OP_MUL;
                nc_r  <= cb;
                kn_r  <= ca;
                err_r <= (ca != rb);
                state_r <= (ca != rb) ? S_OUT : S_RUN;
              end
              default: ;
            endcase
          end
        end
        S_RUN: begin
          rd_ctl_r.first <= (k_r == '0);
          rd_ctl_r.last  <= last_k;
          rd_ctl_r.op    <= op_r;
          if (last_k) begin
            k_r     <= '0;
            state_r <= S_DRAIN;
          end else begin
            k_r <= k_r + mase_pkg::IDX_W'(1);
          end
        end
        S_DRAIN: begin
          if (mac_done) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            if (err_r) begin
              out_data_r <= '{status: 1'b1, out_row: '0, out_col: '0,
                              out_value: '0, last: 1'b1};
              state_r    <= S_IDLE;
            end else begin
              out_data_r <= '{status: 1'b0, out_row: i_r, out_col: j_r,
                              out_value: mase_pkg::VALUE_W'(mac_acc_s),
                              last: last_elem};
              if (last_elem) begin
                state_r <= S_IDLE;
              end else begin
                state_r <= S_RUN;
                if ((mase_pkg::SIZE_W'(j_r) + mase_pkg::SIZE_W'(1)) == nc_r) begin
                  j_r <= '0;
                  i_r <= i_r + mase_pkg::IDX_W'(1);
                end else begin
                  j_r <= j_r + mase_pkg::IDX_W'(1);
                end
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // The accumulator only finishes while the sequencer is waiting for it.
  a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> state_r == S_DRAIN)
    else $error("accumulator finished outside the drain state");

  // The operand index never reaches the inner dimension while reads are issued.
  a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN |-> mase_pkg::SIZE_W'(k_r) < kn_r)
    else $error("operand index beyond inner dimension");

  // A refused run reaches the output state straight from idle.
  a_err_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && err_r) |-> ($past(state_r) == S_IDLE || $past(state_r) == S_OUT))
    else $error("mismatch beat after a started run");

  // Memory reads are issued only by the sequencer's run state.
  a_read_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    rd_ctl_r.valid |-> $past(state_r) == S_RUN)
    else $error("operand read outside a run");

endmodule

/* sim/matrix_add_sub_mul_engine_tb.sv */
module matrix_add_sub_mul_engine_tb;

  localparam int RANDOM_ITEMS  = 420;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 10_000_000;

  localparam logic ST_ELEM     = 1'b0;
  localparam logic ST_MISMATCH = 1'b1;

  // Request codes the block ignores.
  localparam logic [mase_pkg::REQ_W-1:0] REQ_SPARE_A = 3'd5;
  localparam logic [mase_pkg::REQ_W-1:0] REQ_SPARE_B = 3'd6;
  localparam logic [mase_pkg::REQ_W-1:0] REQ_SPARE_C = 3'd7;

  typedef enum logic [1:0] {
    ROW_SEND,
    ROW_TYPED,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t                        kind;
    logic [mase_pkg::CFG_IDX_W-1:0]   reg_sel;
    logic [mase_pkg::SIZE_W-1:0]      reg_val;
    mase_pkg::in_item_t               item;
    logic                             want_status;
    logic [mase_pkg::VALUE_W-1:0]     want_value;
  } dir_row_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  mase_pkg::in_item_t             in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  mase_pkg::out_item_t            out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [mase_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mase_pkg::SIZE_W-1:0]    cfg_data = '0;

  // Shadow copy of the block: size registers and both element stores.
  logic [mase_pkg::SIZE_W-1:0]  sz_rows_a = 4'd1;
  logic [mase_pkg::SIZE_W-1:0]  sz_cols_a = 4'd1;
  logic [mase_pkg::SIZE_W-1:0]  sz_rows_b = 4'd1;
  logic [mase_pkg::SIZE_W-1:0]  sz_cols_b = 4'd1;
  logic [mase_pkg::VALUE_W-1:0] a_elems [mase_pkg::DEPTH];
  logic [mase_pkg::VALUE_W-1:0] b_elems [mase_pkg::DEPTH];
  bit                           a_loaded [mase_pkg::DEPTH];
  bit                           b_loaded [mase_pkg::DEPTH];

  mase_pkg::out_item_t run_out[$];
  mase_pkg::out_item_t expected_beats[$];
  dir_row_t            dir_tab[$];

  bit in_calm = 1'b0;
  bit out_calm = 1'b0;
  int stall_left = 0;
  int fail_count = 0;
  int beats_checked = 0;
  int requests_done = 0;
  int runs_done = 0;
  int runs_refused = 0;
  int size_writes = 0;
  int cycle_count = 0;

  matrix_add_sub_mul_engine DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic logic [mase_pkg::SIZE_W-1:0] fit_size(
      input logic [mase_pkg::SIZE_W-1:0] v);
    logic [mase_pkg::SIZE_W-1:0] r;
    r = v;
    if (v == 0) begin
      r = mase_pkg::SIZE_W'(1);
    end else if (v > mase_pkg::MAX_DIM) begin
      r = mase_pkg::SIZE_W'(mase_pkg::MAX_DIM);
    end
    return r;
  endfunction

  function automatic bit sizes_fit(input logic [mase_pkg::REQ_W-1:0] op);
    logic [mase_pkg::SIZE_W-1:0] ra, ca, rb, cb;
    ra = fit_size(sz_rows_a);
    ca = fit_size(sz_cols_a);
    rb = fit_size(sz_rows_b);
    cb = fit_size(sz_cols_b);
    if (op == mase_pkg::REQ_MUL) begin
      return ca == rb;
    end
    return ra == rb && ca == cb;
  endfunction

  // Applies one accepted request to the shadow state; any result beats land in run_out.
  function automatic void model_request(input mase_pkg::in_item_t it);
    logic [mase_pkg::SIZE_W-1:0]  nr, nc, depth_k;
    logic [mase_pkg::VALUE_W-1:0] acc;
    mase_pkg::out_item_t          r;
    int                           at;
    run_out.delete();
    at = it.elem_row * mase_pkg::MAX_DIM + it.elem_col;
    case (it.req_type)
      mase_pkg::REQ_LOAD_A: begin
        a_elems[at] = it.elem_value;
        a_loaded[at] = 1'b1;
      end
      mase_pkg::REQ_LOAD_B: begin
        b_elems[at] = it.elem_value;
        b_loaded[at] = 1'b1;
      end
      mase_pkg::REQ_ADD, mase_pkg::REQ_SUB, mase_pkg::REQ_MUL: begin
        if (!sizes_fit(it.req_type)) begin
          r = '0;
          r.status = ST_MISMATCH;
          r.last = 1'b1;
          run_out.push_back(r);
        end else begin
          nr = fit_size(sz_rows_a);
          depth_k = fit_size(sz_cols_a);
          nc = (it.req_type == mase_pkg::REQ_MUL) ? fit_size(sz_cols_b) : depth_k;
          for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < nc; j++) begin
              acc = '0;
              if (it.req_type == mase_pkg::REQ_MUL) begin
                for (int k = 0; k < depth_k; k++) begin
                  acc = acc + a_elems[i * mase_pkg::MAX_DIM + k] *
                              b_elems[k * mase_pkg::MAX_DIM + j];
                end
              end else if (it.req_type == mase_pkg::REQ_ADD) begin
                acc = a_elems[i * mase_pkg::MAX_DIM + j] + b_elems[i * mase_pkg::MAX_DIM + j];
              end else begin
                acc = a_elems[i * mase_pkg::MAX_DIM + j] - b_elems[i * mase_pkg::MAX_DIM + j];
              end
              r.status = ST_ELEM;
              r.out_row = mase_pkg::IDX_W'(i);
              r.out_col = mase_pkg::IDX_W'(j);
              r.out_value = acc;
              r.last = (i == nr - 1) && (j == nc - 1);
              run_out.push_back(r);
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [mase_pkg::VALUE_W-1:0] rand_value();
    int s;
    s = $urandom_range(0, 16);
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0;
      4, 5, 6: return mase_pkg::VALUE_W'(s - 8);
      default: return $urandom;
    endcase
  endfunction

  // Most sizes stay small so that loads do not swamp the run; a few hit the edges.
  function automatic logic [mase_pkg::SIZE_W-1:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return mase_pkg::SIZE_W'($urandom_range(1, 3));
    if (r < 78) return mase_pkg::SIZE_W'($urandom_range(4, 7));
    if (r < 84) return mase_pkg::SIZE_W'(mase_pkg::MAX_DIM);
    if (r < 90) return '0;
    if (r < 94) return mase_pkg::SIZE_W'($urandom_range(9, 15));
    return mase_pkg::SIZE_W'(1);
  endfunction

  function automatic mase_pkg::in_item_t noise_item();
    mase_pkg::in_item_t it;
    it.elem_row = mase_pkg::IDX_W'($urandom);
    it.elem_col = mase_pkg::IDX_W'($urandom);
    it.elem_value = rand_value();
    case ($urandom_range(0, 2))
      0: it.req_type = mase_pkg::REQ_LOAD_A;
      1: it.req_type = mase_pkg::REQ_LOAD_B;
      default: it.req_type = mase_pkg::REQ_W'($urandom_range(REQ_SPARE_A, REQ_SPARE_C));
    endcase
    return it;
  endfunction

  function automatic dir_row_t row_item(input row_kind_t kind,
                                        input logic [mase_pkg::REQ_W-1:0] req,
                                        input logic [mase_pkg::IDX_W-1:0] r,
                                        input logic [mase_pkg::IDX_W-1:0] c,
                                        input logic [mase_pkg::VALUE_W-1:0] v,
                                        input logic st,
                                        input logic [mase_pkg::VALUE_W-1:0] want);
    dir_row_t d;
    d = '0;
    d.kind = kind;
    d.item = {req, r, c, v};
    d.want_status = st;
    d.want_value = want;
    return d;
  endfunction

  function automatic dir_row_t row_cfg(input logic [mase_pkg::CFG_IDX_W-1:0] sel,
                                       input logic [mase_pkg::SIZE_W-1:0] val);
    dir_row_t d;
    d = '0;
    d.kind = ROW_CFG;
    d.reg_sel = sel;
    d.reg_val = val;
    return d;
  endfunction

  // A typed row carries its single expected beat; other rows go to the predictor.
  task automatic send_item(input mase_pkg::in_item_t it, input bit typed, input logic want_st,
                           input logic [mase_pkg::VALUE_W-1:0] want_val);
    int                  gap;
    mase_pkg::out_item_t w;
    gap = in_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model_request(it);
    if (it.req_type <= mase_pkg::REQ_MUL) begin
      requests_done++;
    end
    if (run_out.size() > 0) begin
      runs_done++;
      if (run_out[0].status == ST_MISMATCH) begin
        runs_refused++;
      end
    end
    if (typed) begin
      w = '0;
      w.status = want_st;
      w.out_value = want_val;
      w.last = 1'b1;
      expected_beats.push_back(w);
    end else begin
      foreach (run_out[n]) expected_beats.push_back(run_out[n]);
    end
  endtask

  // Holds the sender until every expected beat is out and the block has settled.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic write_reg(input logic [mase_pkg::CFG_IDX_W-1:0] sel,
                           input logic [mase_pkg::SIZE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (sel)
      mase_pkg::CFG_ROWS_A: sz_rows_a = val;
      mase_pkg::CFG_COLS_A: sz_cols_a = val;
      mase_pkg::CFG_ROWS_B: sz_rows_b = val;
      mase_pkg::CFG_COLS_B: sz_cols_b = val;
      default: ;
    endcase
    size_writes++;
  endtask

  // Loads the operands a fitting run will read, in random order with some noise mixed in.
  task automatic stage_operands(input logic [mase_pkg::REQ_W-1:0] op);
    mase_pkg::in_item_t          pending[$];
    mase_pkg::in_item_t          it;
    logic [mase_pkg::SIZE_W-1:0] ra, ca, rb, cb;
    bit                          fresh;
    int                          pick;
    ra = fit_size(sz_rows_a);
    ca = fit_size(sz_cols_a);
    rb = fit_size(sz_rows_b);
    cb = fit_size(sz_cols_b);
    fresh = ($urandom_range(0, 3) != 0);
    if (!sizes_fit(op)) return;
    for (int i = 0; i < ra; i++) begin
      for (int k = 0; k < ca; k++) begin
        if (fresh || !a_loaded[i * mase_pkg::MAX_DIM + k]) begin
          pending.push_back({mase_pkg::REQ_LOAD_A, mase_pkg::IDX_W'(i), mase_pkg::IDX_W'(k),
                             rand_value()});
        end
      end
    end
    for (int i = 0; i < rb; i++) begin
      for (int k = 0; k < cb; k++) begin
        if (fresh || !b_loaded[i * mase_pkg::MAX_DIM + k]) begin
          pending.push_back({mase_pkg::REQ_LOAD_B, mase_pkg::IDX_W'(i), mase_pkg::IDX_W'(k),
                             rand_value()});
        end
      end
    end
    while (pending.size() > 0) begin
      if ($urandom_range(0, 11) == 0) begin
        send_item(noise_item(), 1'b0, ST_ELEM, '0);
      end
      pick = $urandom_range(0, pending.size() - 1);
      it = pending[pick];
      pending.delete(pick);
      send_item(it, 1'b0, ST_ELEM, '0);
    end
  endtask

  task automatic random_phase();
    logic [mase_pkg::SIZE_W-1:0] ra, ca, rb, cb;
    logic [mase_pkg::REQ_W-1:0]  op;
    mase_pkg::in_item_t          it;
    int                          shape;
    ra = pick_size();
    ca = pick_size();
    shape = $urandom_range(0, 9);
    if (shape < 4) begin
      rb = ra;
      cb = ca;
    end else if (shape < 8) begin
      rb = ca;
      cb = pick_size();
    end else begin
      rb = pick_size();
      cb = pick_size();
    end
    wait_quiet();
    write_reg(mase_pkg::CFG_ROWS_A, ra);
    write_reg(mase_pkg::CFG_COLS_A, ca);
    write_reg(mase_pkg::CFG_ROWS_B, rb);
    write_reg(mase_pkg::CFG_COLS_B, cb);
    cfg_valid <= 1'b0;
    in_calm = ($urandom_range(0, 4) == 0);
    out_calm = ($urandom_range(0, 4) == 0);
    repeat ($urandom_range(1, 3)) begin
      if (shape >= 4 && shape < 8 && $urandom_range(0, 4) != 0) begin
        op = mase_pkg::REQ_MUL;
      end else if ($urandom_range(0, 4) == 0) begin
        op = mase_pkg::REQ_MUL;
      end else begin
        op = $urandom_range(0, 1) ? mase_pkg::REQ_ADD : mase_pkg::REQ_SUB;
      end
      stage_operands(op);
      it = noise_item();
      it.req_type = op;
      send_item(it, 1'b0, ST_ELEM, '0);
      if ($urandom_range(0, 9) == 0) begin
        wait_quiet();
      end
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (!out_calm && $urandom_range(0, 3) == 0) begin
        stall_left <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin : check_results
    mase_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      beats_checked++;
      if (expected_beats.size() == 0) begin
        fail_count++;
        $display("%0t: result beat %h arrived with nothing expected", $time, out_data);
      end else begin
        want = expected_beats.pop_front();
        if (out_data.status !== want.status) begin
          fail_count++;
          $display("%0t: status expected %0d got %0d", $time, want.status, out_data.status);
        end
        if (out_data.out_row !== want.out_row) begin
          fail_count++;
          $display("%0t: out_row expected %0d got %0d", $time, want.out_row, out_data.out_row);
        end
        if (out_data.out_col !== want.out_col) begin
          fail_count++;
          $display("%0t: out_col expected %0d got %0d", $time, want.out_col, out_data.out_col);
        end
        if (out_data.out_value !== want.out_value) begin
          fail_count++;
          $display("%0t: out_value expected %h got %h", $time, want.out_value,
                   out_data.out_value);
        end
        if (out_data.last !== want.last) begin
          fail_count++;
          $display("%0t: last expected %0d got %0d", $time, want.last, out_data.last);
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run stalled with %0d result beats outstanding", $time,
             expected_beats.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int directed_count;

    // Reset sizes are 1x1, so the first runs touch element (0,0) only.
    dir_tab.push_back(row_item(ROW_SEND, mase_pkg::REQ_LOAD_A, 3'd0, 3'd0, 32'h7fff_ffff,
                               ST_ELEM, '0));
    dir_tab.push_back(row_item(ROW_SEND, mase_pkg::REQ_LOAD_B, 3'd0, 3'd0, 32'h0000_0001,
                               ST_ELEM, '0));
    dir_tab.push_back(row_item(ROW_TYPED, mase_pkg::REQ_ADD, 3'd0, 3'd0, '0,
                               ST_ELEM, 32'h8000_0000));
    dir_tab.push_back(row_item(ROW_TYPED, mase_pkg::REQ_SUB, 3'd0, 3'd0, '0,
                               ST_ELEM, 32'h7fff_fffe));
    dir_tab.push_back(row_item(ROW_TYPED, mase_pkg::REQ_MUL, 3'd0, 3'd0, '0,
                               ST_ELEM, 32'h7fff_ffff));
    dir_tab.push_back(row_item(ROW_SEND, mase_pkg::REQ_LOAD_A, 3'd0, 3'd0, 32'h8000_0000,
                               ST_ELEM, '0));
    dir_tab.push_back(row_item(ROW_SEND, mase_pkg::REQ_LOAD_B, 3'd0, 3'd0, 32'hffff_ffff,
                               ST_ELEM, '0));
    dir_tab.push_back(row_item(ROW_TYPED, mase_pkg::REQ_ADD, 3'd0, 3'd0, '0,
                               ST_ELEM, 32'h7fff_ffff));
    dir_tab.push_back(row_item(ROW_TYPED, mase_pkg::REQ_SUB, 3'd0, 3'd0, '0,
                               ST_ELEM, 32'h8000_0001));
    dir_tab.push_back(row_item(ROW_TYPED, mase_pkg::REQ_MUL, 3'd0, 3'd0, '0,
                               ST_ELEM, 32'h8000_0000));
    dir_tab.push_back(row_item(ROW_SEND, REQ_SPARE_A, 3'd7, 3'd7, 32'hffff_ffff, ST_ELEM, '0));
    dir_tab.push_back(row_item(ROW_SEND, REQ_SPARE_B, 3'd0, 3'd7, 32'h0, ST_ELEM, '0));
    dir_tab.push_back(row_item(ROW_SEND, REQ_SPARE_C, 3'd7, 3'd0, 32'h5555_5555, ST_ELEM, '0));
    dir_tab.push_back(row_item(ROW_SEND, mase_pkg::REQ_LOAD_A, 3'd7, 3'd7, 32'haaaa_aaaa,
                               ST_ELEM, '0));
    dir_tab.push_back(row_item(ROW_SEND, mase_pkg::REQ_LOAD_B, 3'd7, 3'd7, 32'h5555_5555,
                               ST_ELEM, '0));
    dir_tab.push_back(row_item(ROW_SEND, mase_pkg::REQ_ADD, 3'd5, 3'd2, 32'h1234_5678,
                               ST_ELEM, '0));
    dir_tab.push_back(row_cfg(mase_pkg::CFG_COLS_A, 4'd2));
    dir_tab.push_back(row_item(ROW_TYPED, mase_pkg::REQ_ADD, 3'd0, 3'd0, '0, ST_MISMATCH, '0));
    dir_tab.push_back(row_item(ROW_TYPED, mase_pkg::REQ_MUL, 3'd0, 3'd0, '0, ST_MISMATCH, '0));
    dir_tab.push_back(row_cfg(mase_pkg::CFG_ROWS_B, 4'd2));
    dir_tab.push_back(row_item(ROW_TYPED, mase_pkg::REQ_SUB, 3'd0, 3'd0, '0, ST_MISMATCH, '0));
    // Out-of-range sizes: 15 acts as 8 and 0 acts as 1.
    dir_tab.push_back(row_cfg(mase_pkg::CFG_ROWS_A, 4'd15));
    dir_tab.push_back(row_cfg(mase_pkg::CFG_COLS_A, 4'd0));
    dir_tab.push_back(row_cfg(mase_pkg::CFG_COLS_B, 4'd0));
    dir_tab.push_back(row_item(ROW_TYPED, mase_pkg::REQ_ADD, 3'd0, 3'd0, '0, ST_MISMATCH, '0));
    dir_tab.push_back(row_item(ROW_TYPED, mase_pkg::REQ_MUL, 3'd0, 3'd0, '0, ST_MISMATCH, '0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[n]) begin
      if (dir_tab[n].kind == ROW_CFG) begin
        wait_quiet();
        write_reg(dir_tab[n].reg_sel, dir_tab[n].reg_val);
        cfg_valid <= 1'b0;
      end else begin
        send_item(dir_tab[n].item, dir_tab[n].kind == ROW_TYPED, dir_tab[n].want_status,
                  dir_tab[n].want_value);
      end
    end

    directed_count = requests_done;
    while (requests_done - directed_count < RANDOM_ITEMS) begin
      random_phase();
    end

    wait_quiet();
    $display("Sent %0d requests with %0d runs, %0d of them refused on size mismatch.",
             requests_done, runs_done, runs_refused);
    $display("Checked %0d result beats over %0d cycles and %0d size register writes.",
             beats_checked, cycle_count, size_writes);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
